// File: design/lvar_pkg.sv
// Shared types and constants for the 3x3 local variance block.
package lvar_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPW    = 2;
	localparam int unsigned QCW    = 3;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;

	// eight neighbours of one interior centre, plus end-of-frame mark
	typedef struct packed {
		logic [7:0][7:0] nb;
		logic            last;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} entry_t;

endpackage

// File: design/local_variance_3x3.sv
// Top level of the streaming 3x3 local variance (contrast) block.
//
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------
// pixel    | pixel_valid / pixel_stall | pixel[7:0], frame_start
// result   | result_valid/result_stall | contrast[7:0], frame_last
// config   | cfg_wr_en                 | cfg_index, cfg_data[15:0]
//
// One pixel beat per clock while pixel_stall is low.
// The line-store RAM port and a four-entry window queue set the pace; the queue
// lets the back end stall without stopping pixel intake until it fills.
// Reset clears counters, window and control; line stores are not cleared.
// Border pixels are taken but give no result beat.
module local_variance_3x3 #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	output logic [7:0]  contrast,
	output logic        frame_last,
	output logic        result_valid,
	input  logic        result_stall
);

	logic [12:0]               image_width_q;
	logic [15:0]               image_height_q;
	lvar_pkg::entry_t          push, head;
	logic                      pop;
	logic [lvar_pkg::QCW-1:0]  q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= lvar_pkg::WIDTH_RESET;
			image_height_q <= lvar_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lvar_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[12:0];
				end
				lvar_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	lvar_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.pixel       (pixel),
		.frame_start (frame_start),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.q_count     (q_count),
		.push        (push)
	);

	lvar_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.count (q_count)
	);

	lvar_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.contrast    (contrast),
		.frame_last  (frame_last),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

// File: design/lvar_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lvar_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/lvar_front.sv
// Front end: position counters, line stores, 3x3 window and border classification.
module lvar_front #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [12:0]             image_width,
	input  logic [15:0]             image_height,
	input  logic [7:0]              pixel,
	input  logic                    frame_start,
	input  logic                    pixel_valid,
	output logic                    pixel_stall,
	input  logic [lvar_pkg::QCW-1:0] q_count,
	output lvar_pkg::entry_t        push
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned CMPW = (CW + 1 > 13) ? CW + 1 : 13;

	logic          accept;
	logic [CW-1:0] col_q, col_a;
	logic [15:0]   row_q, row_a;
	logic [CW:0]   col_inc;
	logic [16:0]   row_inc;
	logic [12:0]   wcl;
	logic [15:0]   hcl;
	logic          last_col, last_row, interior;

	logic          v_s1, interior_s1, last_s1;
	logic [7:0]    px_s1;
	logic [CW-1:0] col_s1;

	logic [15:0]   rd_data, eff, wr_data, byp_q;
	logic          hit_q;
	logic [7:0]    a1, a2;
	logic [7:0]    win_q [3][2];

	assign pixel_stall = (4'(q_count) + 4'(v_s1)) >= 4'(lvar_pkg::QDEPTH);
	assign accept      = pixel_valid && !pixel_stall;

	assign col_a   = frame_start ? '0 : col_q;
	assign row_a   = frame_start ? '0 : row_q;
	assign col_inc = {1'b0, col_a} + 1'b1;
	assign row_inc = {1'b0, row_a} + 17'd1;
	assign wcl     = (image_width < 13'd3) ? 13'd3 : image_width;
	assign hcl     = (image_height < 16'd3) ? 16'd3 : image_height;

	assign last_col = (CMPW'(col_inc) >= CMPW'(wcl)) || (CMPW'(col_inc) >= CMPW'(MAX_WIDTH));
	assign last_row = row_inc >= {1'b0, hcl};
	assign interior = (row_a >= 16'd2) && (col_a >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			v_s1        <= 1'b0;
			interior_s1 <= 1'b0;
			last_s1     <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			v_s1  <= accept;
			hit_q <= accept && v_s1 && (col_s1 == col_a);
			if (accept) begin
				interior_s1 <= interior;
				last_s1     <= last_col && last_row;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_inc[15:0];
				end else begin
					col_q <= col_inc[CW-1:0];
					row_q <= row_a;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= wr_data;
		if (accept) begin
			px_s1  <= pixel;
			col_s1 <= col_a;
		end
	end

	// {two rows up, one row up} for each column
	lvar_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(col_s1),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(col_a),
		.rd_data(rd_data)
	);

	// same column written on the edge it was read
	assign eff     = hit_q ? byp_q : rd_data;
	assign a1      = eff[7:0];
	assign a2      = eff[15:8];
	assign wr_data = {a1, px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else if (v_s1) begin
			win_q[0][0] <= win_q[0][1];
			win_q[1][0] <= win_q[1][1];
			win_q[2][0] <= win_q[2][1];
			win_q[0][1] <= a2;
			win_q[1][1] <= a1;
			win_q[2][1] <= px_s1;
		end
	end

	// centre win_q[1][1] is left out
	always_comb begin
		push.valid      = v_s1 && interior_s1;
		push.item.last  = last_s1;
		push.item.nb[0] = win_q[0][0];
		push.item.nb[1] = win_q[0][1];
		push.item.nb[2] = a2;
		push.item.nb[3] = win_q[1][0];
		push.item.nb[4] = a1;
		push.item.nb[5] = win_q[2][0];
		push.item.nb[6] = win_q[2][1];
		push.item.nb[7] = px_s1;
	end

endmodule

// File: design/lvar_queue.sv
// Short FIFO of classified windows between front and back.
module lvar_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lvar_pkg::entry_t         push,
	input  logic                     pop,
	output lvar_pkg::entry_t         head,
	output logic [lvar_pkg::QCW-1:0] count
);

	lvar_pkg::item_t            mem_q [lvar_pkg::QDEPTH];
	logic [lvar_pkg::QPW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [lvar_pkg::QCW-1:0]   count_q;

	assign count      = count_q;
	assign head.valid = count_q != '0;
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + lvar_pkg::QCW'(push.valid) - lvar_pkg::QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

// File: design/lvar_back.sv
// Back end: mean, squared deviations and wrapped sum, with output register.
module lvar_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lvar_pkg::entry_t head,
	output logic             pop,
	output logic [7:0]       contrast,
	output logic             frame_last,
	output logic             result_valid,
	input  logic             result_stall
);

	logic            v_s1, v_s2, out_v_q;
	logic            last_s1, last_s2;
	logic [7:0][7:0] nb_s1, sq_s2;
	logic [7:0]      mu_s1;
	logic            rdy_out, rdy_s2, rdy_s1;

	logic [10:0]     sum;
	logic [7:0][7:0] sq;
	logic [7:0]      acc;

	assign rdy_out = !out_v_q || !result_stall;
	assign rdy_s2  = !v_s2 || rdy_out;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign pop     = head.valid && rdy_s1;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + 11'(head.item.nb[i]);
		end
	end

	always_comb begin
		logic [7:0]  d;
		logic [15:0] p;
		for (int i = 0; i < 8; i++) begin
			d     = (nb_s1[i] >= mu_s1) ? nb_s1[i] - mu_s1 : mu_s1 - nb_s1[i];
			p     = d * d;
			sq[i] = p[7:0];
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + sq_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= head.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			nb_s1   <= head.item.nb;
			mu_s1   <= sum[10:3];
			last_s1 <= head.item.last;
		end
		if (rdy_s2 && v_s1) begin
			sq_s2   <= sq;
			last_s2 <= last_s1;
		end
		if (rdy_out && v_s2) begin
			contrast   <= acc;
			frame_last <= last_s2;
		end
	end

	assign result_valid = out_v_q;

endmodule

// File: tb/tb_local_variance_3x3.sv
// Self-checking testbench for the 3x3 local variance block: directed frames, random frames.
`timescale 1ns / 100ps

module tb_local_variance_3x3;

	localparam int LINE_DEPTH    = 4096;
	localparam int DRAIN_CYCLES  = 24;
	localparam int HOLD_CYCLES   = 320;
	localparam int RANDOM_PIXELS = 1150;
	localparam int WIDE_PIXELS   = 200;
	localparam int HOLD_PIXELS   = 150;
	localparam int DIR_N         = 29;

	typedef struct packed {
		logic [7:0] contrast;
		logic       last;
	} contrast_beat_t;

	typedef struct packed {
		logic [7:0] px;
		logic       fs;
		logic       typed;
		logic [7:0] contrast;
		logic       last;
	} pixel_row_t;

	// 3x3 frames with width and height clamped up from 0 and 2
	localparam pixel_row_t DIR_ROWS [DIR_N] = '{
		'{8'd255, 1'b1, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b1, 8'd0, 1'b1},
		// next frame follows the natural wrap, no start flag
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b1, 8'd0, 1'b1},
		// partial frame cut short by a start flag
		'{8'd17,  1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd200, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b1, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd128, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{8'd1,   1'b0, 1'b0, 8'd0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic [7:0]  pixel;
	logic        frame_start;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [7:0]  contrast;
	logic        frame_last;
	logic        result_valid;
	logic        result_stall;

	local_variance_3x3 #(
		.MAX_WIDTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel),
		.frame_start(frame_start),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.contrast(contrast),
		.frame_last(frame_last),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	// predictor state
	logic [7:0]  row_above [LINE_DEPTH];
	logic [7:0]  row_above2 [LINE_DEPTH];
	logic [7:0]  win [3][3];
	logic [11:0] col_cnt;
	logic [15:0] row_cnt;
	logic [12:0] width_reg;
	logic [15:0] height_reg;

	contrast_beat_t expected_contrast [$];
	contrast_beat_t want;

	int  mismatches;
	int  pixels_sent;
	int  beats_checked;
	int  size_settings;
	int  stall_left;
	bit  hold_req;
	bit  tx_quiet;
	bit  rx_quiet;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("local_variance_3x3 regression: fail");
		$finish;
	end

	function automatic int pick_idle(input int pct);
		int r;
		if ($urandom_range(0, 99) >= pct) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 8);
		return $urandom_range(9, 20);
	endfunction

	function automatic int eff_width();
		int w;
		w = width_reg;
		if (w < 3) w = 3;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		return w;
	endfunction

	task automatic predict_pixel(input logic [7:0] px, input logic fs, output logic hit,
			output contrast_beat_t beat);
		int w, h, r, c, v, sum, mu, d, acc;
		logic [7:0] a1, a2;
		logic lc, lr;
		w = eff_width();
		h = height_reg;
		if (h < 3) h = 3;
		if (fs) begin
			col_cnt = '0;
			row_cnt = '0;
		end
		a2 = row_above2[col_cnt];
		a1 = row_above[col_cnt];
		row_above2[col_cnt] = a1;
		row_above[col_cnt] = px;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = a2;
		win[1][2] = a1;
		win[2][2] = px;
		lc = (col_cnt >= w - 1);
		lr = (row_cnt >= h - 1);
		hit = (row_cnt >= 2) && (col_cnt >= 2);
		sum = 0;
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				if (r != 1 || c != 1) sum += win[r][c];
		mu = sum >> 3;
		acc = 0;
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				if (r != 1 || c != 1) begin
					v = win[r][c];
					d = (v >= mu) ? v - mu : mu - v;
					acc += d * d;
				end
		beat.contrast = acc[7:0];
		beat.last = lc && lr;
		if (lc) begin
			col_cnt = '0;
			row_cnt = lr ? 16'd0 : row_cnt + 16'd1;
		end else begin
			col_cnt = col_cnt + 12'd1;
		end
	endtask

	task automatic send_pixel(input logic [7:0] px, input logic fs, input logic typed,
			input contrast_beat_t typed_beat);
		int gap;
		logic hit;
		contrast_beat_t beat;
		gap = tx_quiet ? 0 : pick_idle(30);
		repeat (gap) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
		end
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel <= px;
		frame_start <= fs;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		predict_pixel(px, fs, hit, beat);
		if (typed) begin
			beat = typed_beat;
			hit = 1'b1;
		end
		if (hit) expected_contrast.push_back(beat);
		pixels_sent++;
	endtask

	// block idle: nothing pending, then let the pipeline run dry
	task automatic settle();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (expected_contrast.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [12:0] w, input logic [15:0] h);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= lvar_pkg::REG_IMAGE_WIDTH;
		cfg_data <= {3'($urandom_range(0, 7)), w};
		@(negedge clk);
		cfg_index <= lvar_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		width_reg = w;
		height_reg = h;
		size_settings++;
	endtask

	// result side stall pattern, with one long hold on request
	initial begin
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = pick_idle(rx_quiet ? 0 : 25);
			end
			result_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			beats_checked++;
			if (expected_contrast.size() == 0) begin
				$display("%0t: unexpected result beat: contrast %0d frame_last %0b",
					$time, contrast, frame_last);
				mismatches++;
			end else begin
				want = expected_contrast.pop_front();
				if (contrast !== want.contrast) begin
					$display("%0t: contrast expected %0d actual %0d",
						$time, want.contrast, contrast);
					mismatches++;
				end
				if (frame_last !== want.last) begin
					$display("%0t: frame_last expected %0b actual %0b",
						$time, want.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int i, k, n, phase, random_sent, old_w;
		logic [12:0] w;
		logic [15:0] h;
		logic keep_going, fs;
		contrast_beat_t typed_beat;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = lvar_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		pixel = '0;
		frame_start = 1'b0;
		pixel_valid = 1'b0;
		hold_req = 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		mismatches = 0;
		pixels_sent = 0;
		beats_checked = 0;
		size_settings = 0;
		for (i = 0; i < LINE_DEPTH; i++) begin
			row_above[i] = '0;
			row_above2[i] = '0;
		end
		for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
		col_cnt = '0;
		row_cnt = '0;
		width_reg = lvar_pkg::WIDTH_RESET;
		height_reg = lvar_pkg::HEIGHT_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_size(13'd0, 16'd2);
		for (i = 0; i < DIR_N; i++) begin
			typed_beat.contrast = DIR_ROWS[i].contrast;
			typed_beat.last = DIR_ROWS[i].last;
			send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].fs, DIR_ROWS[i].typed, typed_beat);
		end
		settle();

		// widest line setting, clamped from the top of the width field; part of one row
		set_size(13'h1FFF, 16'd3);
		for (i = 0; i < WIDE_PIXELS; i++)
			send_pixel(8'($urandom_range(0, 255)), i == 0, 1'b0, '0);
		settle();

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			phase++;
			k = $urandom_range(0, 99);
			if (k < 10) w = 13'($urandom_range(0, 2));
			else if (k < 85) w = 13'($urandom_range(3, 12));
			else w = 13'($urandom_range(13, 40));
			k = $urandom_range(0, 99);
			if (k < 10) h = 16'($urandom_range(0, 2));
			else if (k < 18) h = 16'hFFFF;
			else h = 16'($urandom_range(3, 8));
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				w = 13'd3;
				h = 16'd200;
				tx_quiet = 1'b1;
			end
			old_w = eff_width();
			set_size(w, h);
			// a shrink may land mid-frame; a wider line needs a fresh frame
			keep_going = (eff_width() <= old_w) && ($urandom_range(0, 1) == 1) && (phase != 3);
			if (phase == 3) hold_req = 1'b1;
			n = (phase == 3) ? HOLD_PIXELS : $urandom_range(20, 150);
			for (k = 0; k < n; k++) begin
				if (k == 0) fs = !keep_going;
				else if (col_cnt == 0 && row_cnt == 0) fs = ($urandom_range(0, 1) == 1);
				else fs = ($urandom_range(0, 99) < 3);
				send_pixel(8'($urandom_range(0, 255)), fs, 1'b0, '0);
				random_sent++;
			end
			settle();
		end

		$display("covered %0d pixel beats over %0d size settings, incl. the widest line setting",
			pixels_sent, size_settings);
		$display("compared %0d contrast beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0 && expected_contrast.size() == 0) begin
			$display("local_variance_3x3 regression: pass");
		end else begin
			$display("local_variance_3x3 regression: fail");
		end
		$finish;
	end

endmodule
